@@ design/lfpr_pkg.sv @@
// shared types and constants for the length-framed packet receiver
// no dependencies; compiled first
package lfpr_pkg;

    // result kind codes
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_GOOD    = 2'd1;
    localparam t_kind KIND_BAD     = 2'd2;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_len;

    // configuration register map
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;
    localparam t_byte       SYNC_RESET  = 8'hAA;
    localparam logic        REG_SYNC    = 1'b0;  // register index taken from paddr[2]

endpackage

@@ design/lfpr_if.sv @@
// valid/ready channel interfaces: received bytes in, deframed results out
// depends on lfpr_pkg
interface lfpr_byte_if;
    import lfpr_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfpr_result_if;
    import lfpr_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_byte data;
    t_byte packet_type;
    t_len  payload_length;
    t_len  byte_index;

    modport source (
        output valid, output kind, output data, output packet_type,
        output payload_length, output byte_index, input ready
    );
    modport sink (
        input valid, input kind, input data, input packet_type,
        input payload_length, input byte_index, output ready
    );
endinterface

@@ design/lfpr_deframer.sv @@
// framing state machine, running checksum and result register
// depends on lfpr_pkg and lfpr_if
module lfpr_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfpr_pkg::t_byte    i_sync_byte,
    lfpr_byte_if.sink          i_rx,
    lfpr_result_if.source      o_res
);
    import lfpr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    t_phase r_phase,   n_phase;
    t_len   r_length,  n_length;
    t_byte  r_type,    n_type;
    t_len   r_count,   n_count;
    t_byte  r_xor,     n_xor;

    logic   r_out_valid, n_out_valid;
    t_kind  r_out_kind,  n_out_kind;
    t_byte  r_out_data,  n_out_data;
    t_len   r_out_index, n_out_index;
    t_byte  r_out_type,  n_out_type;
    t_len   r_out_len,   n_out_len;

    logic   w_accept;
    logic   w_emit;
    t_len   w_count_inc;

    // take a new byte whenever the result register is free or being drained
    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign w_accept    = i_rx.valid && i_rx.ready;
    assign w_count_inc = r_count + 16'd1;

    // next state for one received byte
    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_type   = r_type;
        n_count  = r_count;
        n_xor    = r_xor;
        w_emit   = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_index = r_out_index;
        if (w_accept) begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_length = {i_rx.rx_byte, 8'h00};
                    n_xor    = i_rx.rx_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = {r_length[15:8], i_rx.rx_byte};
                    n_xor    = r_xor ^ i_rx.rx_byte;
                    n_phase  = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_rx.rx_byte;
                    n_xor   = r_xor ^ i_rx.rx_byte;
                    n_count = '0;
                    // zero length goes straight to the checksum byte
                    n_phase = (r_length == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    w_emit      = 1'b1;
                    n_out_kind  = KIND_PAYLOAD;
                    n_out_data  = i_rx.rx_byte;
                    n_out_index = r_count;
                    n_xor       = r_xor ^ i_rx.rx_byte;
                    n_count     = w_count_inc;
                    if (w_count_inc == r_length) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    w_emit      = 1'b1;
                    n_out_kind  = (r_xor == i_rx.rx_byte) ? KIND_GOOD : KIND_BAD;
                    n_out_data  = i_rx.rx_byte;
                    n_out_index = r_count;
                    n_phase     = PH_HUNT;
                end
                default: begin
                    n_phase = (i_rx.rx_byte == i_sync_byte) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
        end
    end

    // result register: load on emit, clear once taken
    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_type  = r_out_type;
        n_out_len   = r_out_len;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_type  = r_type;
            n_out_len   = r_length;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_length    <= '0;
            r_type      <= '0;
            r_count     <= '0;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_length    <= n_length;
            r_type      <= n_type;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_out_valid <= n_out_valid;
        end
        r_out_kind  <= n_out_kind;
        r_out_data  <= n_out_data;
        r_out_index <= n_out_index;
        r_out_type  <= n_out_type;
        r_out_len   <= n_out_len;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out_kind;
    assign o_res.data           = r_out_data;
    assign o_res.packet_type    = r_out_type;
    assign o_res.payload_length = r_out_len;
    assign o_res.byte_index     = r_out_index;

    // payload count never passes the declared length inside a packet
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_CHECK) |-> (r_count <= r_length))
        else $error("payload count beyond declared length");

    // payload results carry an index inside the packet
    a_payload_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PAYLOAD) |-> (r_out_index < r_out_len))
        else $error("payload byte index out of range");

    // end markers report the full payload count
    a_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_GOOD || r_out_kind == KIND_BAD))
        |-> (r_out_index == r_out_len))
        else $error("end marker count differs from declared length");

    // header bytes never produce a result
    a_header_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase != PH_PAYLOAD && r_phase != PH_CHECK)
        |=> (r_out_valid == $past(r_out_valid && !o_res.ready)))
        else $error("result produced for a header byte");

endmodule

@@ design/length_framed_packet_receiver.sv @@
// length-framed packet receiver: one received byte per transfer in, payload bytes
// and packet end markers out. Result appears in the cycle after its byte is
// accepted; a byte can be accepted every cycle unless o_res stalls, set by the
// single result register stage. Synchronous active-low reset returns to sync
// hunting with sync byte 0xAA. Depends on lfpr_pkg, lfpr_if and lfpr_deframer
module length_framed_packet_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfpr_pkg::PADDR_W-1:0]  paddr,
    input  logic [lfpr_pkg::PDATA_W-1:0]  pwdata,
    output logic [lfpr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    lfpr_byte_if.sink                     i_rx,
    lfpr_result_if.source                 o_res
);
    import lfpr_pkg::*;

    t_byte r_sync;
    logic  w_reg_hit;

    // register decode on the word index
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[2] == REG_SYNC);

    // sync byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_sync <= pwdata[7:0];
        end
    end

    // read back
    assign prdata = w_reg_hit ? {{(PDATA_W-8){1'b0}}, r_sync} : '0;

    lfpr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sync_byte (r_sync),
        .i_rx        (i_rx),
        .o_res       (o_res)
    );

endmodule
